>>> rtl/core/btff_pkg.sv
package btff_pkg;

  localparam int unsigned GranuleBytes = 8;
  localparam int unsigned GranuleShift = 3;

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef struct packed {
    logic [11:0] payload_offset;
    logic        failed;
  } result_t;

endpackage

>>> rtl/core/btff_if.sv
interface btff_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  opcode;
  logic [12:0] request_size;
  logic [11:0] block_offset;

  modport source (output valid, output opcode, output request_size, output block_offset,
                  input ready);
  modport sink (input valid, input opcode, input request_size, input block_offset,
                output ready);
endinterface

interface btff_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] payload_offset;
  logic [0:0]  failed;

  modport source (output valid, output payload_offset, output failed, input ready);
  modport sink (input valid, input payload_offset, input failed, output ready);
endinterface

>>> rtl/core/boundary_tag_first_fit_allocator_core.sv
// channel  | dir | payload                                  | handshake
// req_if   | in  | opcode, request_size, block_offset       | valid/ready
// rsp_if   | out | payload_offset, failed                   | valid/ready
//
// one word at a time: the sequencer walks the tag memory one chunk header per
// read; allocate walks first fit from the hint, writes header and footer (and
// those of the remainder on a split) and walks on when the hint moves on; free
// walks ownership from unit zero up to the freed chunk; a rejected free or an
// allocate with no hint goes straight to the result
// after reset a clearing pass writes every tag entry before the first word is
// taken; the result register also holds the working offset, so a stalled sink
// holds the next word out until it takes the pending result
module boundary_tag_first_fit_allocator_core #(
  parameter int unsigned HEAP_BYTES      = 4096,
  parameter int unsigned MIN_SPLIT_UNITS = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  btff_req_if.sink     req_if,
  btff_rsp_if.source   rsp_if
);

  localparam int unsigned NumUnits = (HEAP_BYTES + btff_pkg::GranuleBytes - 1) /
                                     btff_pkg::GranuleBytes;
  localparam int unsigned UW = $clog2(NumUnits + 1);   // holds NumUnits itself
  localparam int unsigned AW = (NumUnits > 1) ? $clog2(NumUnits) : 1;
  localparam int unsigned TW = UW + 1;                 // size plus used bit

  typedef enum logic [21:0] {
    StClear   = 22'h000001,
    StIdle    = 22'h000002,
    StAWalkR  = 22'h000004,   // issue header read
    StAWalkC  = 22'h000008,   // check header
    StAWr1    = 22'h000010,
    StAWr2    = 22'h000020,
    StAWr3    = 22'h000040,
    StAWr4    = 22'h000080,
    StAHintR  = 22'h000100,
    StAHintC  = 22'h000200,
    StANfR    = 22'h000400,
    StANfC    = 22'h000800,
    StFWalkR  = 22'h001000,
    StFWalkC  = 22'h002000,
    StFPrevR  = 22'h004000,
    StFPrevC  = 22'h008000,
    StFNextR  = 22'h010000,
    StFNextC  = 22'h020000,
    StFWr1    = 22'h040000,
    StFWr2    = 22'h080000,
    StOut     = 22'h100000,
    StHold    = 22'h200000
  } state_e;

  logic [TW-1:0] tag_mem [NumUnits];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) tag_mem[waddr] <= wdata;
    rdata_q <= tag_mem[raddr];
  end

  state_e        state_q, state_d;
  logic [UW-1:0] cur_q, cur_d;       // walk cursor
  logic [UW-1:0] need_q, need_d;
  logic [UW-1:0] csize_q, csize_d;   // chunk size / free size
  logic [UW-1:0] chunk_q, chunk_d;   // chunk start
  logic [UW-1:0] tgt_q, tgt_d;       // free target unit
  logic [UW-1:0] hint_q, hint_d;
  logic          hvalid_q, hvalid_d;
  logic          split_q, split_d;
  logic [11:0]   poff_q, poff_d;
  logic          fail_q, fail_d;
  logic          ovld_q, ovld_d;

  logic [UW-1:0] rsize;
  logic          rused;
  logic [UW-1:0] step;
  logic [13:0]   need_full;
  logic [UW+1:0] tgt_full;

  assign rsize = rdata_q[TW-1:1];
  assign rused = rdata_q[0];
  assign step  = (rsize == '0) ? UW'(1) : rsize;
  // request plus header, rounded up to units
  assign need_full = 14'((15'(req_if.request_size) + 15'(2 * btff_pkg::GranuleBytes - 1))
                         >> btff_pkg::GranuleShift);
  assign tgt_full  = (UW + 2)'(req_if.block_offset >> btff_pkg::GranuleShift) - (UW + 2)'(1);

  assign req_if.ready = (state_q == StIdle) && !(ovld_q && !rsp_if.ready);
  assign rsp_if.valid = ovld_q;
  assign rsp_if.payload_offset = poff_q;
  assign rsp_if.failed = fail_q;

  always_comb begin
    state_d = state_q; cur_d = cur_q; need_d = need_q; csize_d = csize_q;
    chunk_d = chunk_q; tgt_d = tgt_q; hint_d = hint_q; hvalid_d = hvalid_q;
    split_d = split_q; poff_d = poff_q; fail_d = fail_q;
    ovld_d  = ovld_q && !rsp_if.ready;
    we = 1'b0; waddr = cur_q[AW-1:0]; wdata = '0; raddr = cur_q[AW-1:0];

    unique case (state_q)
      StClear: begin
        we = 1'b1;
        wdata = ((cur_q == '0) || (cur_q == UW'(NumUnits - 1))) ?
                {UW'(NumUnits), 1'b0} : '0;
        cur_d = cur_q + 1'b1;
        if (cur_q == UW'(NumUnits - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (req_if.valid && req_if.ready) begin
          poff_d = '0; fail_d = 1'b0;
          if (req_if.opcode == btff_pkg::OpAlloc) begin
            // oversize need saturates to all ones, which is at least the heap size
            need_d = (32'(need_full) > NumUnits) ? '1 : UW'(need_full);
            cur_d = hint_q;
            if (!hvalid_q || hint_q >= UW'(NumUnits)) begin
              fail_d = 1'b1; state_d = StOut;
            end else begin
              state_d = StAWalkR;
            end
          end else begin
            if (req_if.block_offset == '0 ||
                req_if.block_offset[btff_pkg::GranuleShift-1:0] != '0 ||
                tgt_full >= (UW + 2)'(NumUnits)) begin
              state_d = StOut;
            end else begin
              tgt_d = UW'(tgt_full); cur_d = '0; state_d = StFWalkR;
            end
          end
        end
      end
      StAWalkR: begin
        if (cur_q >= UW'(NumUnits)) begin
          fail_d = 1'b1; state_d = StOut;
        end else begin
          state_d = StAWalkC;
        end
      end
      StAWalkC: begin
        if (!rused && rsize >= need_q) begin
          csize_d = rsize;
          split_d = (rsize - need_q) >= UW'(MIN_SPLIT_UNITS);
          state_d = StAWr1;
        end else begin
          cur_d = cur_q + step; state_d = StAWalkR;
        end
      end
      StAWr1: begin
        we = 1'b1; waddr = cur_q[AW-1:0];
        wdata = {split_q ? need_q : csize_q, 1'b1};
        state_d = StAWr2;
      end
      StAWr2: begin
        we = 1'b1;
        waddr = AW'(cur_q + (split_q ? need_q : csize_q) - 1'b1);
        wdata = {split_q ? need_q : csize_q, 1'b1};
        state_d = split_q ? StAWr3 : StAHintR;
      end
      StAWr3: begin
        we = 1'b1; waddr = AW'(cur_q + need_q);
        wdata = {csize_q - need_q, 1'b0};
        state_d = StAWr4;
      end
      StAWr4: begin
        we = 1'b1; waddr = AW'(cur_q + csize_q - 1'b1);
        wdata = {csize_q - need_q, 1'b0};
        csize_d = need_q;
        state_d = StAHintR;
      end
      StAHintR: begin
        raddr = hint_q[AW-1:0];
        poff_d = 12'((32'(cur_q) + 32'd1) << btff_pkg::GranuleShift);
        state_d = StAHintC;
      end
      StAHintC: begin
        if (rused) begin
          cur_d = cur_q + csize_q; state_d = StANfR;
        end else begin
          state_d = StOut;
        end
      end
      StANfR: begin
        if (cur_q >= UW'(NumUnits)) begin
          hint_d = '0; hvalid_d = 1'b0; state_d = StOut;
        end else begin
          state_d = StANfC;
        end
      end
      StANfC: begin
        if (!rused && rsize >= UW'(1)) begin
          hint_d = cur_q; state_d = StOut;
        end else begin
          cur_d = cur_q + step; state_d = StANfR;
        end
      end
      StFWalkR: begin
        if (cur_q >= tgt_q) begin
          state_d = (cur_q == tgt_q) ? StFWalkC : StOut;
        end else begin
          state_d = StFWalkC;
        end
      end
      StFWalkC: begin
        if (cur_q == tgt_q) begin
          if (rused) begin
            chunk_d = tgt_q; csize_d = rsize;
            raddr = AW'(tgt_q - 1'b1);
            state_d = (tgt_q == '0) ? StFNextR : StFPrevC;
          end else begin
            state_d = StOut;
          end
        end else begin
          cur_d = cur_q + step; state_d = StFWalkR;
        end
      end
      StFPrevR: state_d = StFPrevC;
      StFPrevC: begin
        // previous footer; chunk itself now counts as free
        if (!rused && rsize >= UW'(1) && rsize <= chunk_q) begin
          chunk_d = chunk_q - rsize; csize_d = csize_q + rsize;
        end
        state_d = StFNextR;
      end
      StFNextR: begin
        raddr = AW'(chunk_q + csize_q);
        state_d = StFNextC;
      end
      StFNextC: begin
        if ((chunk_q + csize_q) < UW'(NumUnits) && !rused) csize_d = csize_q + rsize;
        state_d = StFWr1;
      end
      StFWr1: begin
        we = 1'b1; waddr = chunk_q[AW-1:0]; wdata = {csize_q, 1'b0};
        state_d = StFWr2;
      end
      StFWr2: begin
        we = 1'b1; waddr = AW'(chunk_q + csize_q - 1'b1); wdata = {csize_q, 1'b0};
        if (!hvalid_q || chunk_q < hint_q) begin
          hint_d = chunk_q; hvalid_d = 1'b1;
        end
        state_d = StOut;
      end
      StOut: begin
        if (!ovld_q || rsp_if.ready) begin
          ovld_d = 1'b1; state_d = StIdle;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (rsp_if.ready) begin
          ovld_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      cur_q    <= '0;
      hint_q   <= '0;
      hvalid_q <= 1'b1;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      hint_q   <= hint_d;
      hvalid_q <= hvalid_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    csize_q <= csize_d;
    chunk_q <= chunk_d;
    tgt_q   <= tgt_d;
    split_q <= split_d;
    poff_q  <= poff_d;
    fail_q  <= fail_d;
  end

endmodule
